/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the color distance block.
// Defining ASSERT_OFF before inclusion turns every check into nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* rtl/srgbde_pkg.sv */
// Constants, tables and formats for the sRGB to Lab color distance pipeline.
// Depends on nothing; used by srgb_lab_color_distance.
`default_nettype none

package srgbde_pkg;

    localparam int DIST_FRAC_BITS_DEF = 6;

    // Linearized sRGB channel in Q16, indexed by the 8-bit code.
    typedef logic [16:0] lin_tab_t [256];

    function automatic lin_tab_t lin_table_f();
        lin_tab_t tab;
        longint unsigned t;
        longint unsigned t2;
        longint unsigned v;
        longint unsigned r;
        longint unsigned cand;
        int c;
        int s;
        for (c = 0; c < 256; c++)
        begin
            if (c < 11)
            begin
                tab[c] = 17'((longint'(c) * 6553600 + 164730) / 329460);
            end
            else
            begin
                t = ((longint'(c) * 1000 + 14025) * 65536 + 134512) / 269025;
                t2 = t * t;
                v = t2 << 28;
                r = 0;
                // Fifth root, one result bit at a time.
                for (s = 12; s >= 0; s--)
                begin
                    cand = r | (64'd1 << s);
                    if (cand <= 64'd4096 && cand * cand * cand * cand * cand <= v)
                    begin
                        r = cand;
                    end
                end
                tab[c] = 17'((t2 * r + (64'd1 << 27)) >> 28);
            end
        end
        return tab;
    endfunction

    localparam lin_tab_t LIN_TABLE = lin_table_f();

    // sRGB to XYZ matrix rows (x, y, z), four decimals scaled by 10000.
    localparam logic [13:0] XYZ_COEF [3][3] = '{
        '{14'd4124, 14'd3576, 14'd1805},
        '{14'd2126, 14'd7152, 14'd722},
        '{14'd193,  14'd1192, 14'd9505}
    };
    localparam logic [3:0]  XYZ_SCALE [3] = '{4'd10, 4'd1, 4'd10};
    localparam logic [16:0] XYZ_BIAS  [3] = '{17'd48206, 17'd5000, 17'd41166};
    localparam logic [16:0] XYZ_DIV   [3] = '{17'd96413, 17'd10000, 17'd82333};
    localparam int RECIP_SH = 40;
    localparam logic [26:0] XYZ_RECIP [3] = '{
        27'((64'd1 << RECIP_SH) / 64'd96413),
        27'((64'd1 << RECIP_SH) / 64'd10000),
        27'((64'd1 << RECIP_SH) / 64'd82333)
    };

    // Linear segment of the Lab companding curve.
    localparam logic [16:0] LAB_KNEE    = 17'd580;
    localparam logic [30:0] LAB_LIN_MUL = 31'd903292;
    localparam logic [30:0] LAB_LIN_ADD = 31'd1048634000;
    localparam logic [17:0] LAB_LIN_DIV = 18'd116000;
    localparam logic [23:0] LAB_LIN_RECIP = 24'((64'd1 << RECIP_SH) / 64'd116000);

    localparam logic [26:0] L_SCALE = 27'd116;
    localparam logic [26:0] A_SCALE = 27'd500;
    localparam logic [26:0] B_SCALE = 27'd200;

    localparam logic [14:0] OUT_MAX = 15'h7fff;

endpackage

`default_nettype wire

/* rtl/srgb_lab_color_distance.sv */
// CIE76 distance between two sRGB colors: gamma table, XYZ matrix, Lab companding,
// Euclidean norm. Depends on srgbde_pkg and assert_macros.svh.
//
//   channel   direction   payload                                     handshake
//   pair      in          red_a green_a blue_a red_b green_b blue_b   pair_valid/pair_stall
//   dist      out         delta_e                                     dist_valid/dist_stall
//
// One transfer per cycle on each channel while that channel is not stalled; a new pair
// can enter before earlier results have left. The 17-step cube root and the 28-step
// square root take one pipeline stage per step. Every stage has its own valid bit; a
// stage loads when it is empty or when the stage after it moves, so bubbles close up
// under a stalled output. Reset clears only the valid bits.
`default_nettype none
`include "assert_macros.svh"

module srgb_lab_color_distance #(
    parameter int DIST_FRAC_BITS = srgbde_pkg::DIST_FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pair_valid,
    output logic             pair_stall,
    input  wire logic [7:0]  red_a,
    input  wire logic [7:0]  green_a,
    input  wire logic [7:0]  blue_a,
    input  wire logic [7:0]  red_b,
    input  wire logic [7:0]  green_b,
    input  wire logic [7:0]  blue_b,
    output logic             dist_valid,
    input  wire logic        dist_stall,
    output logic [14:0]      delta_e
);

    localparam int ST_LIN   = 0;
    localparam int ST_SUM   = 1;
    localparam int ST_EST   = 2;
    localparam int ST_REM   = 3;
    localparam int ST_V     = 4;
    localparam int ST_LNUM  = 5;
    localparam int ST_LEST  = 6;
    localparam int ST_LREM  = 7;
    localparam int ST_LF    = 8;
    localparam int CB_N     = 17;
    localparam int ST_CB0   = 9;
    localparam int ST_F     = ST_CB0 + CB_N;
    localparam int ST_DIF   = ST_F + 1;
    localparam int ST_MUL   = ST_DIF + 1;
    localparam int ST_SQ    = ST_MUL + 1;
    localparam int ST_SSUM  = ST_SQ + 1;
    localparam int SR_N     = 28;
    localparam int ST_SR0   = ST_SSUM + 1;
    localparam int ST_OUT   = ST_SR0 + SR_N;
    localparam int NST      = ST_OUT + 1;
    localparam int RND_SH   = 16 - DIST_FRAC_BITS;
    localparam logic [28:0] RND = 29'(1) << (RND_SH - 1);

    logic [NST-1:0] vld_reg;
    logic [NST:0]   en;
    logic           in_xfer;
    logic           out_xfer;
    logic [6:0]     fill;

    // Lanes: 0..2 are x, y, z (or r, g, b) of color a, 3..5 of color b.
    logic [7:0]  code [6];
    logic [16:0] lin_next [6];
    logic [16:0] lin_reg [6];
    logic [32:0] num_next [6];
    logic [32:0] num_reg [6];
    logic [16:0] est_next [6];
    logic [16:0] est_reg [6];
    logic [32:0] num2_reg [6];
    logic [17:0] rem_next [6];
    logic [17:0] rem_reg [6];
    logic [16:0] est3_reg [6];
    logic [16:0] v_next [6];
    logic [16:0] v_reg [6];
    logic [30:0] lnum_next [6];
    logic [30:0] lnum_reg [6];
    logic [16:0] v5_reg [6];
    logic [14:0] lest_next [6];
    logic [14:0] lest_reg [6];
    logic [30:0] lnum6_reg [6];
    logic [16:0] v6_reg [6];
    logic [17:0] lrem_next [6];
    logic [17:0] lrem_reg [6];
    logic [14:0] lest7_reg [6];
    logic [16:0] v7_reg [6];
    logic [14:0] lf_next [6];
    logic [14:0] lf_reg [6];
    logic        lsel_next [6];
    logic        lsel_reg [6];
    logic [16:0] v8_reg [6];
    logic [16:0] cr_next [CB_N][6];
    logic [16:0] cr_reg [CB_N][6];
    logic [34:0] cr2_next [CB_N][6];
    logic [34:0] cr2_reg [CB_N][6];
    logic [48:0] crem_next [CB_N][6];
    logic [48:0] crem_reg [CB_N][6];
    logic [14:0] clf_reg [CB_N][6];
    logic        clsel_reg [CB_N][6];
    logic [16:0] f_next [6];
    logic [16:0] f_reg [6];
    logic signed [19:0] dl_next, da_next, db_next;
    logic signed [19:0] dl_reg, da_reg, db_reg;
    logic [26:0] u_next [3];
    logic [26:0] u_reg [3];
    logic [53:0] sq_next [3];
    logic [53:0] sq_reg [3];
    logic [55:0] ss_next;
    logic [55:0] ss_reg;
    logic [27:0] sr_next [SR_N];
    logic [27:0] sr_reg [SR_N];
    logic [55:0] srem_next [SR_N];
    logic [55:0] srem_reg [SR_N];
    logic [14:0] delta_next;
    logic [14:0] delta_reg;

    // ---------------- flow control ----------------

    always_comb
    begin
        en[NST] = !dist_stall;
        for (int k = NST - 1; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= pair_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign pair_stall = !en[0];
    assign dist_valid = vld_reg[NST-1];
    assign delta_e    = delta_reg;

    // ---------------- gamma, matrix and XYZ normalization ----------------

    assign code[0] = red_a;
    assign code[1] = green_a;
    assign code[2] = blue_a;
    assign code[3] = red_b;
    assign code[4] = green_b;
    assign code[5] = blue_b;

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            lin_next[l] = srgbde_pkg::LIN_TABLE[code[l]];
        end
        for (int col = 0; col < 2; col++)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                num_next[col*3+ch] =
                    33'(srgbde_pkg::XYZ_SCALE[ch]) *
                    (33'(srgbde_pkg::XYZ_COEF[ch][0]) * 33'(lin_reg[col*3])
                     + 33'(srgbde_pkg::XYZ_COEF[ch][1]) * 33'(lin_reg[col*3+1])
                     + 33'(srgbde_pkg::XYZ_COEF[ch][2]) * 33'(lin_reg[col*3+2]))
                    + 33'(srgbde_pkg::XYZ_BIAS[ch]);
                // The reciprocal is rounded down, so the estimate is low by at most one.
                est_next[col*3+ch] = 17'((60'(num_reg[col*3+ch])
                    * 60'(srgbde_pkg::XYZ_RECIP[ch])) >> srgbde_pkg::RECIP_SH);
                rem_next[col*3+ch] = 18'(num2_reg[col*3+ch]
                    - 33'(est_reg[col*3+ch]) * 33'(srgbde_pkg::XYZ_DIV[ch]));
                v_next[col*3+ch] = est3_reg[col*3+ch]
                    + 17'(rem_reg[col*3+ch] >= 18'(srgbde_pkg::XYZ_DIV[ch]));
            end
        end
    end

    // ---------------- linear segment of the companding curve ----------------

    always_comb
    begin
        for (int l = 0; l < 6; l++)
        begin
            // Only values at or below the knee use this path, so ten bits suffice.
            lnum_next[l] = srgbde_pkg::LAB_LIN_MUL * 31'(v_reg[l][9:0])
                + srgbde_pkg::LAB_LIN_ADD;
            lest_next[l] = 15'((55'(lnum_reg[l]) * 55'(srgbde_pkg::LAB_LIN_RECIP))
                >> srgbde_pkg::RECIP_SH);
            lrem_next[l] = 18'(lnum6_reg[l]
                - 31'(lest_reg[l]) * 31'(srgbde_pkg::LAB_LIN_DIV));
            lf_next[l]   = lest7_reg[l] + 15'(lrem_reg[l] >= srgbde_pkg::LAB_LIN_DIV);
            lsel_next[l] = (v7_reg[l] <= srgbde_pkg::LAB_KNEE);
        end
    end

    // ---------------- cube root, one result bit per stage ----------------

    always_comb
    begin
        logic [16:0] r_in;
        logic [34:0] r2_in;
        logic [48:0] rem_in;
        logic [55:0] d3;
        int s;
        for (int j = 0; j < CB_N; j++)
        begin
            s = CB_N - 1 - j;
            for (int l = 0; l < 6; l++)
            begin
                if (j == 0)
                begin
                    r_in   = '0;
                    r2_in  = '0;
                    rem_in = {v8_reg[l], 32'b0};
                end
                else
                begin
                    r_in   = cr_reg[j-1][l];
                    r2_in  = cr2_reg[j-1][l];
                    rem_in = crem_reg[j-1][l];
                end
                // (r + 2^s)^3 - r^3, built from the running square and root.
                d3 = 56'(3) * (56'(r2_in) << s) + 56'(3) * (56'(r_in) << (2 * s))
                    + (56'(1) << (3 * s));
                cr_next[j][l]   = r_in;
                cr2_next[j][l]  = r2_in;
                crem_next[j][l] = rem_in;
                if (d3 <= 56'(rem_in))
                begin
                    cr_next[j][l]   = r_in | (17'(1) << s);
                    cr2_next[j][l]  = 35'((36'(r2_in) + (36'(r_in) << (s + 1)))
                        + (36'(1) << (2 * s)));
                    crem_next[j][l] = 49'(56'(rem_in) - d3);
                end
            end
        end
    end

    // ---------------- Lab differences and squared norm ----------------

    always_comb
    begin
        logic [19:0] mag [3];
        for (int l = 0; l < 6; l++)
        begin
            f_next[l] = clsel_reg[CB_N-1][l] ? 17'(clf_reg[CB_N-1][l]) : cr_reg[CB_N-1][l];
        end
        dl_next = $signed({3'b0, f_reg[1]}) - $signed({3'b0, f_reg[4]});
        da_next = ($signed({3'b0, f_reg[0]}) - $signed({3'b0, f_reg[1]}))
                - ($signed({3'b0, f_reg[3]}) - $signed({3'b0, f_reg[4]}));
        db_next = ($signed({3'b0, f_reg[1]}) - $signed({3'b0, f_reg[2]}))
                - ($signed({3'b0, f_reg[4]}) - $signed({3'b0, f_reg[5]}));
        mag[0] = dl_reg[19] ? 20'(-dl_reg) : 20'(dl_reg);
        mag[1] = da_reg[19] ? 20'(-da_reg) : 20'(da_reg);
        mag[2] = db_reg[19] ? 20'(-db_reg) : 20'(db_reg);
        u_next[0] = 27'(mag[0]) * srgbde_pkg::L_SCALE;
        u_next[1] = 27'(mag[1]) * srgbde_pkg::A_SCALE;
        u_next[2] = 27'(mag[2]) * srgbde_pkg::B_SCALE;
        for (int i = 0; i < 3; i++)
        begin
            sq_next[i] = 54'(u_reg[i]) * 54'(u_reg[i]);
        end
        ss_next = 56'(sq_reg[0]) + 56'(sq_reg[1]) + 56'(sq_reg[2]);
    end

    // ---------------- square root, one result bit per stage ----------------

    always_comb
    begin
        logic [27:0] r_in;
        logic [55:0] rem_in;
        logic [57:0] d;
        int s;
        for (int j = 0; j < SR_N; j++)
        begin
            s = SR_N - 1 - j;
            if (j == 0)
            begin
                r_in   = '0;
                rem_in = ss_reg;
            end
            else
            begin
                r_in   = sr_reg[j-1];
                rem_in = srem_reg[j-1];
            end
            d = (58'(r_in) << (s + 1)) + (58'(1) << (2 * s));
            sr_next[j]   = r_in;
            srem_next[j] = rem_in;
            if (d <= 58'(rem_in))
            begin
                sr_next[j]   = r_in | (28'(1) << s);
                srem_next[j] = 56'(58'(rem_in) - d);
            end
        end
    end

    always_comb
    begin
        logic [28:0] q;
        q = (29'(sr_reg[SR_N-1]) + RND) >> RND_SH;
        delta_next = (q > 29'(srgbde_pkg::OUT_MAX)) ? srgbde_pkg::OUT_MAX : q[14:0];
    end

    // ---------------- payload registers ----------------

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 6; l++)
        begin
            if (en[ST_LIN])
            begin
                lin_reg[l] <= lin_next[l];
            end
            if (en[ST_SUM])
            begin
                num_reg[l] <= num_next[l];
            end
            if (en[ST_EST])
            begin
                est_reg[l]  <= est_next[l];
                num2_reg[l] <= num_reg[l];
            end
            if (en[ST_REM])
            begin
                rem_reg[l]  <= rem_next[l];
                est3_reg[l] <= est_reg[l];
            end
            if (en[ST_V])
            begin
                v_reg[l] <= v_next[l];
            end
            if (en[ST_LNUM])
            begin
                lnum_reg[l] <= lnum_next[l];
                v5_reg[l]   <= v_reg[l];
            end
            if (en[ST_LEST])
            begin
                lest_reg[l]  <= lest_next[l];
                lnum6_reg[l] <= lnum_reg[l];
                v6_reg[l]    <= v5_reg[l];
            end
            if (en[ST_LREM])
            begin
                lrem_reg[l]  <= lrem_next[l];
                lest7_reg[l] <= lest_reg[l];
                v7_reg[l]    <= v6_reg[l];
            end
            if (en[ST_LF])
            begin
                lf_reg[l]   <= lf_next[l];
                lsel_reg[l] <= lsel_next[l];
                v8_reg[l]   <= v7_reg[l];
            end
            for (int j = 0; j < CB_N; j++)
            begin
                if (en[ST_CB0 + j])
                begin
                    cr_reg[j][l]    <= cr_next[j][l];
                    cr2_reg[j][l]   <= cr2_next[j][l];
                    crem_reg[j][l]  <= crem_next[j][l];
                    clf_reg[j][l]   <= (j == 0) ? lf_reg[l] : clf_reg[j-1][l];
                    clsel_reg[j][l] <= (j == 0) ? lsel_reg[l] : clsel_reg[j-1][l];
                end
            end
            if (en[ST_F])
            begin
                f_reg[l] <= f_next[l];
            end
        end
        if (en[ST_DIF])
        begin
            dl_reg <= dl_next;
            da_reg <= da_next;
            db_reg <= db_next;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (en[ST_MUL])
            begin
                u_reg[i] <= u_next[i];
            end
            if (en[ST_SQ])
            begin
                sq_reg[i] <= sq_next[i];
            end
        end
        if (en[ST_SSUM])
        begin
            ss_reg <= ss_next;
        end
        for (int j = 0; j < SR_N; j++)
        begin
            if (en[ST_SR0 + j])
            begin
                sr_reg[j]   <= sr_next[j];
                srem_reg[j] <= srem_next[j];
            end
        end
        if (en[ST_OUT])
        begin
            delta_reg <= delta_next;
        end
    end

    // ---------------- assertions ----------------

    assign in_xfer  = pair_valid && !pair_stall;
    assign out_xfer = dist_valid && !dist_stall;
    assign fill     = 7'($countones(vld_reg));

    `ASSERT_CLK(a_stall_needs_item, clk, rst_n, pair_stall |-> vld_reg[0], "stall, stage empty")
    `ASSERT_CLK(a_count_up, clk, rst_n, in_xfer && !out_xfer |=> fill == $past(fill) + 7'd1, "lost on entry")
    `ASSERT_CLK(a_count_down, clk, rst_n, !in_xfer && out_xfer |=> fill + 7'd1 == $past(fill), "lost on exit")

endmodule

`default_nettype wire

/* tb/srgb_lab_color_distance_test.sv */
// Self-checking testbench for srgb_lab_color_distance: random and directed color pairs
// with an independent fixed-point CIE76 predictor. Depends on the RTL and srgbde_pkg.
`timescale 1ns / 1ps

module srgb_lab_color_distance_test;

    localparam int FRAC_BITS = srgbde_pkg::DIST_FRAC_BITS_DEF;
    localparam logic [14:0] DIST_SAT = srgbde_pkg::OUT_MAX;
    localparam int DRAIN_CYCLES = 200;

    typedef longint unsigned u64_t;
    typedef longint s64_t;

    typedef struct {
        logic [7:0] ra;
        logic [7:0] ga;
        logic [7:0] ba;
        logic [7:0] rb;
        logic [7:0] gb;
        logic [7:0] bb;
    } color_pair_t;

    class distance_scoreboard;
        logic [14:0] expected_q[$];
        int failures;

        function new();
            failures = 0;
        endfunction

        function void note_pair(logic [14:0] predicted);
            expected_q.push_back(predicted);
        endfunction

        function void check_dist(logic [14:0] actual);
            logic [14:0] want;
            if (expected_q.size() == 0)
            begin
                $error("delta_e: unexpected transfer, actual %0d", actual);
                failures++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (actual !== want)
                begin
                    $error("delta_e: expected %0d, actual %0d", want, actual);
                    failures++;
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic pair_valid;
    logic pair_stall;
    logic [7:0] red_a;
    logic [7:0] green_a;
    logic [7:0] blue_a;
    logic [7:0] red_b;
    logic [7:0] green_b;
    logic [7:0] blue_b;
    logic dist_valid;
    logic dist_stall;
    logic [14:0] delta_e;

    distance_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    srgb_lab_color_distance u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .pair_valid(pair_valid),
        .pair_stall(pair_stall),
        .red_a(red_a),
        .green_a(green_a),
        .blue_a(blue_a),
        .red_b(red_b),
        .green_b(green_b),
        .blue_b(blue_b),
        .dist_valid(dist_valid),
        .dist_stall(dist_stall),
        .delta_e(delta_e)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // sRGB code to linear light in Q16.
    function automatic u64_t gamma_expand(logic [7:0] code);
        u64_t c;
        u64_t t;
        u64_t t2;
        u64_t v;
        u64_t r;
        u64_t cand;
        c = code;
        if (c < 11)
            return (c * 6553600 + 164730) / 329460;
        t = ((1000 * c + 14025) * 65536 + 134512) / 269025;
        t2 = t * t;
        v = t2 << 28;
        r = 0;
        // t^0.4 in Q12 as the floored fifth root of t^2 scaled up.
        for (int s = 12; s >= 0; s--)
        begin
            cand = r | (u64_t'(1) << s);
            if (cand <= 4096 && cand * cand * cand * cand * cand <= v)
                r = cand;
        end
        return (t2 * r + (u64_t'(1) << 27)) >> 28;
    endfunction

    function automatic s64_t lab_compand(u64_t v);
        u64_t w;
        u64_t r;
        u64_t cand;
        if (v > 580)
        begin
            w = v << 32;
            r = 0;
            for (int s = 16; s >= 0; s--)
            begin
                cand = r | (u64_t'(1) << s);
                if (cand * cand * cand <= w)
                    r = cand;
            end
            return s64_t'(r);
        end
        return s64_t'((u64_t'(7787 * 116) * v + 64'd1048576000 + 58000) / 116000);
    endfunction

    function automatic void color_to_f(input logic [7:0] r8, input logic [7:0] g8,
                                       input logic [7:0] b8,
                                       output s64_t fx, output s64_t fy, output s64_t fz);
        u64_t rl;
        u64_t gl;
        u64_t bl;
        rl = gamma_expand(r8);
        gl = gamma_expand(g8);
        bl = gamma_expand(b8);
        fx = lab_compand(((4124 * rl + 3576 * gl + 1805 * bl) * 10 + 48206) / 96413);
        fy = lab_compand((2126 * rl + 7152 * gl + 722 * bl + 5000) / 10000);
        fz = lab_compand(((193 * rl + 1192 * gl + 9505 * bl) * 10 + 41166) / 82333);
    endfunction

    function automatic u64_t floor_sqrt(u64_t n);
        u64_t res;
        u64_t bitv;
        res = 0;
        bitv = u64_t'(1) << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [14:0] predict_delta_e(color_pair_t p);
        s64_t xa, ya, za, xb, yb, zb;
        s64_t dl, da, db;
        u64_t sum;
        u64_t q;
        color_to_f(p.ra, p.ga, p.ba, xa, ya, za);
        color_to_f(p.rb, p.gb, p.bb, xb, yb, zb);
        dl = 116 * (ya - yb);
        da = 500 * ((xa - ya) - (xb - yb));
        db = 200 * ((ya - za) - (yb - zb));
        sum = u64_t'(dl * dl) + u64_t'(da * da) + u64_t'(db * db);
        q = (floor_sqrt(sum) + (u64_t'(1) << (15 - FRAC_BITS))) >> (16 - FRAC_BITS);
        if (q > DIST_SAT)
            q = DIST_SAT;
        return q[14:0];
    endfunction

    task automatic send_pair(color_pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            pair_valid <= 1'b0;
            @(posedge clk);
        end
        pair_valid <= 1'b1;
        red_a <= p.ra;
        green_a <= p.ga;
        blue_a <= p.ba;
        red_b <= p.rb;
        green_b <= p.gb;
        blue_b <= p.bb;
        do
            @(posedge clk);
        while (pair_stall);
        sb.note_pair(predict_delta_e(p));
    endtask

    task automatic send_colors(int ra, int ga, int ba, int rb, int gb, int bb);
        color_pair_t p;
        p = '{8'(ra), 8'(ga), 8'(ba), 8'(rb), 8'(gb), 8'(bb)};
        send_pair(p);
    endtask

    function automatic logic [7:0] near_code(logic [7:0] c);
        int v;
        v = int'(c) + $urandom_range(8) - 4;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    endfunction

    task automatic send_random(int n);
        color_pair_t p;
        for (int i = 0; i < n; i++)
        begin
            case ($urandom_range(3))
                0:
                begin
                    p = '{8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom)};
                end
                1:
                begin
                    // Close colors, the usual palette-match case.
                    p.ra = 8'($urandom); p.ga = 8'($urandom); p.ba = 8'($urandom);
                    p.rb = near_code(p.ra); p.gb = near_code(p.ga); p.bb = near_code(p.ba);
                end
                2:
                begin
                    // Dark codes around the gamma and Lab knees.
                    p = '{8'($urandom_range(24)), 8'($urandom_range(24)),
                          8'($urandom_range(24)), 8'($urandom_range(24)),
                          8'($urandom_range(24)), 8'($urandom_range(24))};
                end
                default:
                begin
                    p = '{8'($urandom), 8'($urandom), 8'($urandom),
                          8'($urandom), 8'($urandom), 8'($urandom)};
                    if ($urandom_range(1))
                        p.rb = 8'(255 - p.ra);
                    else
                        p.bb = 8'(255 - p.ba);
                end
            endcase
            send_pair(p);
        end
    endtask

    task automatic wait_drained();
        pair_valid <= 1'b0;
        while (sb.expected_q.size() > 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && dist_valid && !dist_stall)
            sb.check_dist(delta_e);
        dist_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    initial
    begin
        #2_000_000;
        $display("srgb_lab_color_distance: mismatch");
        $finish;
    end

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        pair_valid = 1'b0;
        dist_stall = 1'b0;
        {red_a, green_a, blue_a, red_b, green_b, blue_b} = '0;
        send_idle_pct = 12;
        recv_stall_pct = 82;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_colors(0, 0, 0, 255, 255, 255);
        send_colors(255, 255, 255, 0, 0, 0);
        send_colors(0, 0, 0, 0, 0, 0);
        send_colors(255, 255, 255, 255, 255, 255);
        send_colors(255, 0, 0, 0, 255, 0);
        send_colors(0, 255, 0, 0, 0, 255);
        send_colors(0, 0, 255, 255, 255, 0);
        send_colors(255, 0, 255, 0, 255, 0);
        send_colors(10, 10, 10, 11, 11, 11);
        send_colors(11, 0, 0, 10, 0, 0);
        send_colors(1, 1, 1, 0, 0, 0);
        send_colors(128, 128, 128, 127, 127, 127);
        send_colors(85, 170, 85, 170, 85, 170);
        send_colors(0, 0, 255, 255, 255, 255);
        send_colors(255, 255, 0, 0, 0, 255);
        send_colors(0, 255, 255, 255, 0, 0);
        send_random(120);

        // Let the pipeline run dry before changing the traffic pattern.
        wait_drained();
        send_idle_pct = 82;
        recv_stall_pct = 12;
        send_random(130);

        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_random(130);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.failures == 0)
            $display("srgb_lab_color_distance: match");
        else
            $display("srgb_lab_color_distance: mismatch");
        $finish;
    end

endmodule
